// File: src/rce_pkg.sv
// Shared constants, types and codes of the roadmap connection engine.
package rce_pkg;

  localparam int MaxNodesDef = 64;
  localparam int GridRowsDef = 512;
  localparam int GridColsDef = 512;

  localparam int RowOriginCm = 1040;
  localparam int ColOriginCm = 690;
  localparam int CellCm      = 5;
  localparam int FracBits    = 16;

  localparam int LqW   = 29;
  localparam int NumW  = 51;
  localparam int QuoW  = 36;
  localparam int PosW  = 38;
  localparam int BaseW = 13;

  localparam logic [15:0] Div5Mul   = 16'hCCCD;
  localparam int          Div5Shift = 18;

  localparam logic [6:0]  ObstThrRst   = 7'd30;
  localparam logic [10:0] LinkRangeRst = 11'd100;
  localparam logic [6:0]  SampleStepRst = 7'd5;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_OBSTACLE   = 3'd2,
    ST_UNEXPLORED = 3'd3,
    ST_FULL       = 3'd4,
    ST_OUTSIDE    = 3'd5,
    ST_CELL       = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_OBST_THR    = 2'd0,
    CFG_LINK_RANGE  = 2'd1,
    CFG_SAMPLE_STEP = 2'd2
  } cfg_idx_e;

endpackage

// File: src/rce_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module rce_isqrt #(
  parameter int RootW = rce_pkg::LqW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2*RootW-1:0]   radicand_i,
  output logic                 done_o,
  output logic [RootW-1:0]     root_o
);

  localparam int CntW = $clog2(RootW + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [2*RootW-1:0] rad_q;
  logic [RootW+1:0]   rem_q;
  logic [RootW-1:0]   root_q;
  logic [RootW+3:0]   rem_t;
  logic [RootW+3:0]   trial;
  logic               ge;

  assign rem_t = {rem_q, rad_q[2*RootW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (ge) begin
        rem_q  <= (RootW+2)'(rem_t - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t[RootW+1:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: src/rce_div.sv
// Restoring divider, one quotient bit per cycle, with quotient and remainder held.
module rce_div #(
  parameter int NumW = rce_pkg::NumW,
  parameter int DenW = rce_pkg::LqW,
  parameter int QuoW = rce_pkg::QuoW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [QuoW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [QuoW-1:0] quo_q;
  logic [DenW:0]   rem_t;
  logic            ge;

  assign rem_t = {rem_q, num_q[NumW-1]};
  assign ge    = rem_t >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[QuoW-2:0], ge};
      if (ge) begin
        rem_q <= DenW'(rem_t - {1'b0, den_q});
      end else begin
        rem_q <= rem_t[DenW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: src/roadmap_connection_engine.sv
// Top level of the roadmap connection engine: grid store, node store and link sequencer.
//
// The engine takes one item when start_i is high and busy_o is low. A cell-write item
// stores one occupancy cell and answers with a status beat in the next cycle. A node
// item is checked against the fill level, every stored node and its own grid cell; an
// accepted node is then tried against each earlier node: the distance is computed, and
// a node within the link range goes through the square-root unit, the two dividers and
// the collision samples, each sample being one read of the grid memory. Link beats, in
// neighbour order, follow the whole search, then the status beat with last_o set. A
// beat is valid only in the cycle in which res_valid_o is high; the receiver cannot hold
// it off. Registers may be written only while busy_o is low. No memory needs clearing
// after reset.
module roadmap_connection_engine #(
  parameter int MAX_NODES = rce_pkg::MaxNodesDef,
  parameter int GRID_ROWS = rce_pkg::GridRowsDef,
  parameter int GRID_COLS = rce_pkg::GridColsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cmd_i,
  input  logic [8:0]         cell_row_i,
  input  logic [8:0]         cell_col_i,
  input  logic signed [7:0]  cell_value_i,
  input  logic signed [10:0] node_x_i,
  input  logic signed [11:0] node_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_wdata_i,
  output logic               res_valid_o,
  output logic               is_status_o,
  output logic [5:0]         neighbor_index_o,
  output logic [10:0]        link_distance_cm_o,
  output logic [2:0]         status_code_o,
  output logic [5:0]         new_index_o,
  output logic [10:0]        link_count_o,
  output logic               last_o
);

  localparam int IdxW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CntW      = $clog2(MAX_NODES + 1);
  localparam int RowW      = $clog2(GRID_ROWS);
  localparam int ColW      = $clog2(GRID_COLS);
  localparam int GridDepth = GRID_ROWS * GRID_COLS;
  localparam int GridAw    = $clog2(GridDepth);
  localparam int RowLimit  = rce_pkg::CellCm * GRID_ROWS;
  localparam int ColLimit  = rce_pkg::CellCm * GRID_COLS;
  localparam int LqW       = rce_pkg::LqW;
  localparam int QuoW      = rce_pkg::QuoW;
  localparam int PosW      = rce_pkg::PosW;
  localparam int BaseW     = rce_pkg::BaseW;
  localparam int FracBits  = rce_pkg::FracBits;
  localparam int IntW      = PosW - FracBits;
  localparam int LsW       = LqW - FracBits;
  localparam int LbufW     = IdxW + 11;

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_DUP_RD   = 21'h000002,
    S_DUP_CMP  = 21'h000004,
    S_CLS0     = 21'h000008,
    S_CLS1     = 21'h000010,
    S_CLS2     = 21'h000020,
    S_CLS3     = 21'h000040,
    S_CLS4     = 21'h000080,
    S_LNK_RD   = 21'h000100,
    S_LNK_DIF  = 21'h000200,
    S_LNK_MUL  = 21'h000400,
    S_LNK_SUM  = 21'h000800,
    S_LNK_CHK  = 21'h001000,
    S_SQRT     = 21'h002000,
    S_DIV      = 21'h004000,
    S_SMP      = 21'h008000,
    S_LNK_ADD  = 21'h010000,
    S_NEXT     = 21'h020000,
    S_EMIT_RD  = 21'h040000,
    S_EMIT_OUT = 21'h080000,
    S_STATUS   = 21'h100000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]  thr_q;
  logic [10:0] range_q;
  logic [6:0]  step_q;
  logic [CntW-1:0] count_q, count_d;
  logic [10:0] total_q, total_d;

  logic signed [10:0] x_q;
  logic signed [11:0] y_q;
  logic signed [BaseW-1:0] base_r_q, base_c_q;
  logic [IdxW-1:0] idx_q, nidx_q;
  logic [CntW-1:0] nl_q, ej_q;
  rce_pkg::status_e status_q;
  logic node_mode_q;
  logic sx_q, sy_q;
  logic [QuoW-1:0] qx_q, qy_q;
  logic [LqW-1:0]  rx_q, ry_q, lq_q;
  logic [13:0] p_q;
  logic first_q;
  logic [10:0] ax_q;
  logic [11:0] ay_q;
  logic [21:0] sqx_q;
  logic [23:0] sqy_q;
  logic [24:0] d2_q;
  logic [21:0] r2_q;
  logic [17:0] nmx_q;
  logic [18:0] nmy_q;
  logic out_q;
  logic [12:0] rint_q, cint_q;
  logic [RowW-1:0] r_q;
  logic [ColW-1:0] c_q;
  logic [GridAw-1:0] addr_q;

  logic [7:0]  grid_mem [GridDepth];
  logic signed [7:0] grid_rd_q;
  logic [22:0] node_mem [MAX_NODES];
  logic [22:0] node_rd_q;
  logic rd_zero_q;
  logic [LbufW-1:0] lbuf_mem [MAX_NODES];
  logic [LbufW-1:0] lbuf_rd_q;

  logic accept;
  logic grid_we;
  logic [GridAw-1:0] grid_waddr;
  logic [22:0] node_val;
  logic dup_match, dup_last, nbr_last;
  logic [6:0] step_eff;
  logic signed [PosW-1:0] offx_w, offy_w, rn_w, cn_w;
  logic [IntW-1:0] rint_w, cint_w;
  logic out_w;
  logic [28:0] rprod, cprod;
  rce_pkg::status_e cls;
  logic signed [11:0] dxw;
  logic signed [12:0] dyw;
  logic [LsW-1:0] ls;
  logic smp_go;
  logic [LqW:0] rsx, rsy;
  logic cx, cy;

  logic sq_done, dvx_done, dvy_done;
  logic [LqW-1:0] sq_root, rix, riy;
  logic [QuoW-1:0] qix, qiy;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = state_q != S_IDLE;
  assign step_eff = (step_q == 7'd0) ? 7'd1 : step_q;

  assign grid_we = accept && !cmd_i && (11'(cell_row_i) < 11'(GRID_ROWS))
                   && (11'(cell_col_i) < 11'(GRID_COLS));
  assign grid_waddr = GridAw'(cell_row_i) * GridAw'(GRID_COLS) + GridAw'(cell_col_i);

  assign node_val  = rd_zero_q ? '0 : node_rd_q;
  assign dup_match = node_val == {x_q, y_q};
  assign dup_last  = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign nbr_last  = ({1'b0, idx_q} + (IdxW+1)'(1)) == {1'b0, nidx_q};

  assign offx_w = sx_q ? -$signed({2'b00, qx_q}) : $signed({2'b00, qx_q});
  assign offy_w = sy_q ? -$signed({2'b00, qy_q}) : $signed({2'b00, qy_q});
  assign rn_w = $signed({{(IntW-BaseW){base_r_q[BaseW-1]}}, base_r_q, {FracBits{1'b0}}})
                - offy_w;
  assign cn_w = $signed({{(IntW-BaseW){base_c_q[BaseW-1]}}, base_c_q, {FracBits{1'b0}}})
                + offx_w;
  assign rint_w = rn_w[PosW-1:FracBits];
  assign cint_w = cn_w[PosW-1:FracBits];
  assign out_w = rint_w[IntW-1] || cint_w[IntW-1]
                 || (rint_w >= IntW'(RowLimit)) || (cint_w >= IntW'(ColLimit));

  assign rprod = 29'(rint_q) * 29'(rce_pkg::Div5Mul);
  assign cprod = 29'(cint_q) * 29'(rce_pkg::Div5Mul);

  always_comb begin
    if (out_q) begin
      cls = rce_pkg::ST_OUTSIDE;
    end else if (grid_rd_q > $signed({1'b0, thr_q})) begin
      cls = rce_pkg::ST_OBSTACLE;
    end else if (grid_rd_q < 0) begin
      cls = rce_pkg::ST_UNEXPLORED;
    end else begin
      cls = rce_pkg::ST_ADDED;
    end
  end

  assign dxw = $signed({node_val[22], node_val[22:12]}) - $signed({x_q[10], x_q});
  assign dyw = $signed({node_val[11], node_val[11:0]}) - $signed({y_q[11], y_q});

  assign ls     = lq_q[LqW-1:FracBits];
  assign smp_go = first_q || (p_q <= 14'(ls));
  assign rsx = {1'b0, rx_q} + {1'b0, rix};
  assign rsy = {1'b0, ry_q} + {1'b0, riy};
  assign cx  = rsx >= {1'b0, lq_q};
  assign cy  = rsy >= {1'b0, lq_q};

  rce_isqrt #(.RootW(LqW)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((state_q == S_LNK_CHK) && (d2_q < 25'(r2_q))),
    .radicand_i ((2*LqW)'({d2_q, 32'b0})),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  rce_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_SQRT) && sq_done),
    .num_i   (rce_pkg::NumW'({nmx_q, 32'b0})),
    .den_i   (sq_root),
    .done_o  (dvx_done),
    .quo_o   (qix),
    .rem_o   (rix)
  );

  rce_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_SQRT) && sq_done),
    .num_i   (rce_pkg::NumW'({nmy_q, 32'b0})),
    .den_i   (sq_root),
    .done_o  (dvy_done),
    .quo_o   (qiy),
    .rem_o   (riy)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    total_d = total_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!cmd_i || (count_q == CntW'(MAX_NODES))) begin
            state_d = S_STATUS;
          end else begin
            state_d = S_DUP_RD;
          end
        end
      end
      S_DUP_RD: state_d = S_DUP_CMP;
      S_DUP_CMP: begin
        if (dup_match) begin
          state_d = S_STATUS;
        end else if (dup_last) begin
          state_d = S_CLS0;
        end else begin
          state_d = S_DUP_RD;
        end
      end
      S_CLS0: state_d = S_CLS1;
      S_CLS1: state_d = S_CLS2;
      S_CLS2: state_d = S_CLS3;
      S_CLS3: state_d = S_CLS4;
      S_CLS4: begin
        if (node_mode_q) begin
          if (cls == rce_pkg::ST_ADDED) begin
            count_d = count_q + CntW'(1);
            state_d = S_LNK_RD;
          end else begin
            state_d = S_STATUS;
          end
        end else if (cls == rce_pkg::ST_ADDED) begin
          state_d = S_SMP;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_LNK_RD:  state_d = S_LNK_DIF;
      S_LNK_DIF: state_d = S_LNK_MUL;
      S_LNK_MUL: state_d = S_LNK_SUM;
      S_LNK_SUM: state_d = S_LNK_CHK;
      S_LNK_CHK: state_d = (d2_q < 25'(r2_q)) ? S_SQRT : S_NEXT;
      S_SQRT: begin
        if (sq_done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (dvx_done && dvy_done) begin
          state_d = S_SMP;
        end
      end
      S_SMP: state_d = smp_go ? S_CLS0 : S_LNK_ADD;
      S_LNK_ADD: begin
        total_d = total_q + 11'd1;
        state_d = S_NEXT;
      end
      S_NEXT: state_d = nbr_last ? S_EMIT_RD : S_LNK_RD;
      S_EMIT_RD: state_d = (ej_q == nl_q) ? S_STATUS : S_EMIT_OUT;
      S_EMIT_OUT: state_d = S_EMIT_RD;
      S_STATUS: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CntW'(1);
      total_q <= '0;
      thr_q   <= rce_pkg::ObstThrRst;
      range_q <= rce_pkg::LinkRangeRst;
      step_q  <= rce_pkg::SampleStepRst;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rce_pkg::CFG_OBST_THR:    thr_q   <= cfg_wdata_i[6:0];
          rce_pkg::CFG_LINK_RANGE:  range_q <= cfg_wdata_i;
          rce_pkg::CFG_SAMPLE_STEP: step_q  <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= range_q * range_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          x_q         <= node_x_i;
          y_q         <= node_y_i;
          base_r_q    <= $signed(BaseW'(rce_pkg::RowOriginCm))
                         - $signed({node_y_i[11], node_y_i});
          base_c_q    <= $signed(BaseW'(rce_pkg::ColOriginCm))
                         + $signed({{2{node_x_i[10]}}, node_x_i});
          nidx_q      <= '0;
          idx_q       <= '0;
          nl_q        <= '0;
          ej_q        <= '0;
          node_mode_q <= 1'b1;
          qx_q        <= '0;
          qy_q        <= '0;
          sx_q        <= 1'b0;
          sy_q        <= 1'b0;
          if (!cmd_i) begin
            status_q <= rce_pkg::ST_CELL;
          end else if (count_q == CntW'(MAX_NODES)) begin
            status_q <= rce_pkg::ST_FULL;
          end else begin
            status_q <= rce_pkg::ST_ADDED;
          end
        end
      end
      S_DUP_CMP: begin
        if (dup_match) begin
          status_q <= rce_pkg::ST_DUPLICATE;
        end
        idx_q <= dup_last ? '0 : idx_q + IdxW'(1);
      end
      S_CLS0: begin
        out_q  <= out_w;
        rint_q <= rint_w[12:0];
        cint_q <= cint_w[12:0];
      end
      S_CLS1: begin
        r_q <= RowW'(rprod >> rce_pkg::Div5Shift);
        c_q <= ColW'(cprod >> rce_pkg::Div5Shift);
      end
      S_CLS2: addr_q <= GridAw'(r_q) * GridAw'(GRID_COLS) + GridAw'(c_q);
      S_CLS4: begin
        if (node_mode_q) begin
          status_q <= cls;
          if (cls == rce_pkg::ST_ADDED) begin
            nidx_q      <= count_q[IdxW-1:0];
            node_mode_q <= 1'b0;
          end
        end else if (cls == rce_pkg::ST_ADDED) begin
          p_q     <= p_q + 14'(step_eff);
          first_q <= 1'b0;
        end
      end
      S_LNK_DIF: begin
        sx_q <= dxw[11];
        sy_q <= dyw[12];
        ax_q <= dxw[11] ? 11'(-dxw) : dxw[10:0];
        ay_q <= dyw[12] ? 12'(-dyw) : dyw[11:0];
      end
      S_LNK_MUL: begin
        sqx_q <= ax_q * ax_q;
        sqy_q <= ay_q * ay_q;
        nmx_q <= step_eff * ax_q;
        nmy_q <= step_eff * ay_q;
      end
      S_LNK_SUM: d2_q <= 25'(sqx_q) + 25'(sqy_q);
      S_SQRT: begin
        if (sq_done) begin
          lq_q <= sq_root;
        end
      end
      S_DIV: begin
        qx_q    <= '0;
        qy_q    <= '0;
        rx_q    <= '0;
        ry_q    <= '0;
        p_q     <= 14'(step_eff);
        first_q <= 1'b1;
      end
      S_SMP: begin
        if (smp_go) begin
          rx_q <= cx ? LqW'(rsx - {1'b0, lq_q}) : rsx[LqW-1:0];
          ry_q <= cy ? LqW'(rsy - {1'b0, lq_q}) : rsy[LqW-1:0];
          qx_q <= qx_q + qix + QuoW'(cx);
          qy_q <= qy_q + qiy + QuoW'(cy);
        end
      end
      S_LNK_ADD: nl_q <= nl_q + CntW'(1);
      S_NEXT:    idx_q <= idx_q + IdxW'(1);
      S_EMIT_OUT: ej_q <= ej_q + CntW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= cell_value_i;
    end
    grid_rd_q <= grid_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_CLS4) && node_mode_q && (cls == rce_pkg::ST_ADDED)) begin
      node_mem[count_q[IdxW-1:0]] <= {x_q, y_q};
    end
    node_rd_q <= node_mem[idx_q];
    rd_zero_q <= idx_q == '0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LNK_ADD) begin
      lbuf_mem[nl_q[IdxW-1:0]] <= {idx_q, ls[10:0]};
    end
    lbuf_rd_q <= lbuf_mem[ej_q[IdxW-1:0]];
  end

  assign res_valid_o        = (state_q == S_EMIT_OUT) || (state_q == S_STATUS);
  assign is_status_o        = state_q == S_STATUS;
  assign last_o             = state_q == S_STATUS;
  assign neighbor_index_o   = (state_q == S_EMIT_OUT) ? 6'(lbuf_rd_q[LbufW-1:11]) : 6'd0;
  assign link_distance_cm_o = (state_q == S_EMIT_OUT) ? lbuf_rd_q[10:0] : 11'd0;
  assign status_code_o      = (state_q == S_STATUS) ? status_q : rce_pkg::ST_ADDED;
  assign new_index_o        = 6'(nidx_q);
  assign link_count_o       = total_q;

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |=> !busy_o)
    else $error("engine still busy after the closing beat");

  a_link_below_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !is_status_o) |-> (neighbor_index_o < new_index_o))
    else $error("link beat names a neighbour that is not older than the new node");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ((count_q >= CntW'(1)) && (count_q <= CntW'(MAX_NODES))))
    else $error("node count out of range");
`endif

endmodule

// File: tb/rce_result_checker.sv
// Checker that predicts and compares every result beat of the roadmap connection engine.
module rce_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cmd_i,
  input  logic [8:0]         cell_row_i,
  input  logic [8:0]         cell_col_i,
  input  logic signed [7:0]  cell_value_i,
  input  logic signed [10:0] node_x_i,
  input  logic signed [11:0] node_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               res_valid_i,
  input  logic               is_status_i,
  input  logic [5:0]         neighbor_index_i,
  input  logic [10:0]        link_distance_cm_i,
  input  logic [2:0]         status_code_i,
  input  logic [5:0]         new_index_i,
  input  logic [10:0]        link_count_i,
  input  logic               last_i,
  output int                 err_count_o,
  output int                 outstanding_o,
  output int                 nodes_stored_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridCells = rce_pkg::GridRowsDef * rce_pkg::GridColsDef;

  typedef struct {
    logic             is_status;
    logic [5:0]       neighbour;
    logic [10:0]      dist_cm;
    rce_pkg::status_e code;
    logic [5:0]       new_idx;
    logic [10:0]      links;
    logic             last;
  } beat_t;

  beat_t             pending_beats[$];
  logic signed [7:0] occ_cells[0:GridCells-1];
  int                node_xs[rce_pkg::MaxNodesDef];
  int                node_ys[rce_pkg::MaxNodesDef];
  int                n_nodes;
  logic [10:0]       links_total;
  int                obst_thr;
  int                range_cm;
  int                step_cm;

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rce_pkg::status_e cell_class(longint xq, longint yq);
    longint unit, rn, cn, r, c;
    logic signed [7:0] v;
    unit = longint'(rce_pkg::CellCm) << rce_pkg::FracBits;
    rn = (longint'(rce_pkg::RowOriginCm) << rce_pkg::FracBits) - yq;
    cn = (longint'(rce_pkg::ColOriginCm) << rce_pkg::FracBits) + xq;
    if (rn < 0 || cn < 0) return rce_pkg::ST_OUTSIDE;
    r = rn / unit;
    c = cn / unit;
    if (r >= rce_pkg::GridRowsDef || c >= rce_pkg::GridColsDef) return rce_pkg::ST_OUTSIDE;
    v = occ_cells[r*rce_pkg::GridColsDef + c];
    if (int'(v) > obst_thr) return rce_pkg::ST_OBSTACLE;
    if (v < 0) return rce_pkg::ST_UNEXPLORED;
    return rce_pkg::ST_ADDED;
  endfunction

  function automatic longint sample_offset(int d, longint unsigned p, longint unsigned lq);
    longint unsigned mag, off;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    off = ((p * mag) << 32) / lq;
    return (d < 0) ? -longint'(off) : longint'(off);
  endfunction

  function automatic bit segment_clear(int xs, int ys, int dx, int dy, longint unsigned d2);
    longint unsigned st, lq, kmax, p;
    longint xq, yq;
    st = (step_cm != 0) ? longint'(step_cm) : 1;
    lq = sqrt_floor(d2 << 32);
    kmax = sqrt_floor(d2) / st;
    if (kmax < 1) kmax = 1;
    for (longint unsigned k = 1; k <= kmax; k++) begin
      p = k * st;
      xq = longint'(xs) * 65536 + sample_offset(dx, p, lq);
      yq = longint'(ys) * 65536 + sample_offset(dy, p, lq);
      if (cell_class(xq, yq) != rce_pkg::ST_ADDED) return 0;
    end
    return 1;
  endfunction

  task automatic predict_item();
    beat_t            found[$];
    beat_t            b;
    rce_pkg::status_e code;
    int               x, y, dx, dy;
    bit               dup;
    logic [5:0]       nidx;
    longint unsigned  d2, r2;
    nidx = '0;
    if (!cmd_i) begin
      occ_cells[int'(cell_row_i)*rce_pkg::GridColsDef + int'(cell_col_i)] = cell_value_i;
      code = rce_pkg::ST_CELL;
    end else begin
      x = int'(node_x_i);
      y = int'(node_y_i);
      dup = 0;
      if (n_nodes >= rce_pkg::MaxNodesDef) begin
        code = rce_pkg::ST_FULL;
      end else begin
        for (int i = 0; i < n_nodes; i++)
          if (node_xs[i] == x && node_ys[i] == y) dup = 1;
        code = dup ? rce_pkg::ST_DUPLICATE
                   : cell_class(longint'(x) * 65536, longint'(y) * 65536);
      end
      if (code == rce_pkg::ST_ADDED) begin
        r2 = longint'(range_cm) * longint'(range_cm);
        nidx = n_nodes[5:0];
        node_xs[n_nodes] = x;
        node_ys[n_nodes] = y;
        for (int i = 0; i < n_nodes; i++) begin
          dx = node_xs[i] - x;
          dy = node_ys[i] - y;
          d2 = longint'(dx) * dx + longint'(dy) * dy;
          if (d2 < r2 && segment_clear(x, y, dx, dy, d2)) begin
            links_total = links_total + 1'b1;
            b.is_status = 0;
            b.neighbour = i[5:0];
            b.dist_cm   = 11'(sqrt_floor(d2));
            b.code      = rce_pkg::ST_ADDED;
            b.new_idx   = nidx;
            b.last      = 0;
            found = {found, b};
          end
        end
        n_nodes++;
      end
    end
    b.is_status = 1;
    b.neighbour = '0;
    b.dist_cm   = '0;
    b.code      = code;
    b.new_idx   = nidx;
    b.last      = 1;
    found = {found, b};
    foreach (found[k]) begin
      found[k].links = links_total;
      pending_beats = {pending_beats, found[k]};
    end
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count_o++;
    end
  endtask

  task automatic compare_beat();
    beat_t e;
    if (pending_beats.size() == 0) begin
      $error("result beat with nothing expected");
      err_count_o++;
    end else begin
      e = pending_beats.pop_front();
      check_field("is_status", int'(e.is_status), int'(is_status_i));
      check_field("neighbor_index", int'(e.neighbour), int'(neighbor_index_i));
      check_field("link_distance_cm", int'(e.dist_cm), int'(link_distance_cm_i));
      check_field("status_code", int'(e.code), int'(status_code_i));
      check_field("new_index", int'(e.new_idx), int'(new_index_i));
      check_field("link_count", int'(e.links), int'(link_count_i));
      check_field("last", int'(e.last), int'(last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_beats.delete();
      foreach (node_xs[i]) begin
        node_xs[i] = 0;
        node_ys[i] = 0;
      end
      err_count_o = 0;
      n_nodes     = 1;
      links_total = '0;
      obst_thr    = int'(rce_pkg::ObstThrRst);
      range_cm    = int'(rce_pkg::LinkRangeRst);
      step_cm     = int'(rce_pkg::SampleStepRst);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rce_pkg::CFG_OBST_THR:    obst_thr = int'(cfg_wdata_i[6:0]);
          rce_pkg::CFG_LINK_RANGE:  range_cm = int'(cfg_wdata_i);
          rce_pkg::CFG_SAMPLE_STEP: step_cm  = int'(cfg_wdata_i[6:0]);
          default: ;
        endcase
      end
      if (res_valid_i) compare_beat();
      if (start_i && !busy_i) predict_item();
    end
    outstanding_o  <= pending_beats.size();
    nodes_stored_o <= n_nodes;
  end

endmodule

// File: tb/tb_roadmap_connection_engine.sv
// Testbench top of the roadmap connection engine: clock, reset, stimulus and verdict.
module tb_roadmap_connection_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CfgIdxSpare = 2'd3;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic               cmd = 0;
  logic [8:0]         cell_row = '0;
  logic [8:0]         cell_col = '0;
  logic signed [7:0]  cell_value = '0;
  logic signed [10:0] node_x = '0;
  logic signed [11:0] node_y = '0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_idx = '0;
  logic [10:0]        cfg_wdata = '0;
  logic               res_valid, is_status, last;
  logic [5:0]         neighbor_index, new_index;
  logic [10:0]        link_distance_cm, link_count;
  logic [2:0]         status_code;
  int                 err_count, outstanding, nodes_stored;
  int                 burst_left = 0;
  int                 offered_x[$];
  int                 offered_y[$];

  always #5 clk = ~clk;

  roadmap_connection_engine u_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .cmd_i(cmd),
    .cell_row_i(cell_row), .cell_col_i(cell_col), .cell_value_i(cell_value),
    .node_x_i(node_x), .node_y_i(node_y),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .res_valid_o(res_valid), .is_status_o(is_status), .neighbor_index_o(neighbor_index),
    .link_distance_cm_o(link_distance_cm), .status_code_o(status_code),
    .new_index_o(new_index), .link_count_o(link_count), .last_o(last)
  );

  rce_result_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .cmd_i(cmd),
    .cell_row_i(cell_row), .cell_col_i(cell_col), .cell_value_i(cell_value),
    .node_x_i(node_x), .node_y_i(node_y),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .res_valid_i(res_valid), .is_status_i(is_status), .neighbor_index_i(neighbor_index),
    .link_distance_cm_i(link_distance_cm), .status_code_i(status_code),
    .new_index_i(new_index), .link_count_i(link_count), .last_i(last),
    .err_count_o(err_count), .outstanding_o(outstanding), .nodes_stored_o(nodes_stored)
  );

  // One beat per call; most bursts of back-to-back beats follow a random gap.
  task automatic send_beat(bit c, int row, int col, int val, int x, int y);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    cmd        <= c;
    cell_row   <= 9'(row);
    cell_col   <= 9'(col);
    cell_value <= 8'(val);
    node_x     <= 11'(x);
    node_y     <= 12'(y);
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_cell(int row, int col, int val);
    send_beat(0, row, col, val, $urandom_range(2047) - 1024, $urandom_range(4095) - 2048);
  endtask

  task automatic offer_node(int x, int y);
    offered_x = {offered_x, x};
    offered_y = {offered_y, y};
    send_beat(1, $urandom_range(511), $urandom_range(511), $urandom_range(255) - 128, x, y);
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(int thr, int range, int step);
    cfg_we    <= 1'b1;
    cfg_idx   <= rce_pkg::CFG_OBST_THR;
    cfg_wdata <= 11'(thr);
    @(posedge clk);
    cfg_idx   <= rce_pkg::CFG_LINK_RANGE;
    cfg_wdata <= 11'(range);
    @(posedge clk);
    cfg_idx   <= rce_pkg::CFG_SAMPLE_STEP;
    cfg_wdata <= 11'(step);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int cell_level();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(0, 25);
    if (r < 90) return $urandom_range(31, 127);
    return -int'($urandom_range(1, 128));
  endfunction

  task automatic random_item();
    int sel, k;
    sel = $urandom_range(99);
    if (sel < 25) begin
      if ($urandom_range(3) == 0) write_cell($urandom_range(511), $urandom_range(511),
                                             $urandom_range(255) - 128);
      else write_cell($urandom_range(204, 212), $urandom_range(134, 142), cell_level());
    end else if (sel < 78) begin
      offer_node($urandom_range(40) - 20, $urandom_range(40) - 20);
    end else if (sel < 86) begin
      k = $urandom_range(offered_x.size() - 1);
      offer_node(offered_x[k], offered_y[k]);
    end else begin
      case ($urandom_range(2))
        0: offer_node(-int'($urandom_range(691, 1024)), $urandom_range(4095) - 2048);
        1: offer_node($urandom_range(2047) - 1024, $urandom_range(1041, 2047));
        default: offer_node($urandom_range(2047) - 1024, -int'($urandom_range(1520, 2048)));
      endcase
    end
  endtask

  task automatic random_phase(int n);
    repeat (n) random_item();
    settle();
  endtask

  initial begin
    #400ms;
    $display("tb_roadmap_connection_engine: done, errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every cell that a node or a collision sample can reach is written first.
    for (int r = 204; r <= 212; r++)
      for (int c = 134; c <= 142; c++)
        write_cell(r, c, cell_level());

    write_cell(0, 0, -128);
    write_cell(511, 511, 127);
    write_cell(416, 276, -128);
    write_cell(416, 342, -128);
    write_cell(208, 142, 127);
    write_cell(212, 138, -5);
    write_cell(206, 140, 0);
    offer_node(690, -1040);
    offer_node(1023, -1040);
    offer_node(-1024, 0);
    offer_node(0, 2047);
    offer_node(0, -2048);
    offer_node(0, 0);
    offer_node(20, 0);
    offer_node(0, -20);
    offer_node(10, 10);
    offer_node(10, 10);
    settle();

    random_phase(30);
    set_config(0, 2047, 100);
    random_phase(25);
    set_config(127, 50, 1);
    random_phase(20);
    set_config(60, 0, 7);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgIdxSpare;
    cfg_wdata <= 11'h7FF;
    @(posedge clk);
    cfg_we    <= 1'b0;
    random_phase(25);
    set_config(15, 300, 0);
    random_phase(15);
    set_config(30, 150, 10);
    random_phase(40);
    set_config(45, 2047, 20);
    random_phase(40);

    while (nodes_stored < rce_pkg::MaxNodesDef) begin
      offer_node($urandom_range(40) - 20, $urandom_range(40) - 20);
      settle();
    end
    repeat (5) random_item();
    settle();
    repeat (40) @(posedge clk);

    if (err_count == 0) $display("tb_roadmap_connection_engine: done, clean");
    else $display("tb_roadmap_connection_engine: done, errors");
    $finish;
  end

endmodule
